FILE: sv/trc_pkg.sv
// ----------------------------------------------------------------------------
// trc_pkg
// Shared types and constants of the telemetry ring with acknowledge cursor.
// ----------------------------------------------------------------------------
package trc_pkg;

   localparam int RING_DEPTH_DEF   = 64;
   localparam int PAYLOAD_BITS_DEF = 32;
   localparam int MAX_RESULTS      = 64;

   localparam logic [1:0] REQ_APPEND = 2'd0;
   localparam logic [1:0] REQ_ACK    = 2'd1;
   localparam logic [1:0] REQ_PEEK   = 2'd2;
   localparam logic [1:0] REQ_STATS  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COUNT,
      ST_EMIT,
      ST_RESP
   } state_type;

endpackage

FILE: sv/telemetry_ring_with_ack_cursor_unit.sv
// ----------------------------------------------------------------------------
// telemetry_ring_with_ack_cursor_unit
// Overwriting telemetry ring with a downlink acknowledge cursor.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request item (append, acknowledge, peek, stats); it is
//   taken when req_valid is high and req_stall low. rsp_* carries result
//   items through an output register; rsp_stall holds that register.
//   Rows live in a chain of cells, newest at the head. An append shifts the
//   chain once; every request then rotates the chain a full turn, one cell
//   per cycle, to count pending rows (and rows crossed by an acknowledge).
//   A peek makes a second full turn, emitting pending rows oldest first; it
//   advances only while the output register can take an item.
//   The result of an append, acknowledge or stats is loaded once the
//   counting turn ends; the rows of a peek are loaded in the second turn.
//   One request is in work at a time; req_stall is high until its last
//   result is loaded.
//   Reset clears the row count and all counters but the next sequence
//   number, which restarts at 1; row contents are not cleared. A stalled
//   receiver freezes the emitting turn where it stands.
// ----------------------------------------------------------------------------
module telemetry_ring_with_ack_cursor_unit #(
   parameter int RING_DEPTH   = trc_pkg::RING_DEPTH_DEF,
   parameter int PAYLOAD_BITS = trc_pkg::PAYLOAD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_sample_payload,
   input  logic [31:0] req_tick_ms,
   input  logic [31:0] req_ack_through,
   input  logic [6:0]  req_peek_limit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_record_seq,
   output logic [31:0] rsp_record_time_ms,
   output logic [31:0] rsp_record_payload,
   output logic        rsp_record_valid,
   output logic        rsp_last_of_run,
   output logic [31:0] rsp_appended_total,
   output logic [31:0] rsp_dropped_total,
   output logic [31:0] rsp_downlinked_total,
   output logic [6:0]  rsp_held_rows,
   output logic [6:0]  rsp_pending_rows,
   output logic [31:0] rsp_acked_through_seq,
   output logic [31:0] rsp_next_sequence
);

   localparam int SW = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam int NW = (CW > 7) ? CW : 7;
   localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);
   localparam logic [SW-1:0] STEP_END = SW'(RING_DEPTH - 1);
   localparam logic [6:0]    MAX_C = 7'(trc_pkg::MAX_RESULTS);

   // cell chain
   logic [31:0]             cell_seq     [RING_DEPTH];
   logic [31:0]             cell_time    [RING_DEPTH];
   logic [PAYLOAD_BITS-1:0] cell_payload [RING_DEPTH];
   logic [31:0]             head_seq;
   logic [31:0]             head_time;
   logic [PAYLOAD_BITS-1:0] head_payload;
   logic                    move;

   trc_pkg::state_type state_ff, state_in;

   logic [1:0]  type_ff;
   logic [31:0] ack_ff;
   logic [6:0]  limit_ff;
   logic [SW-1:0] step_ff, step_in;
   logic [CW-1:0] held_ff, held_in;
   logic [CW-1:0] pend_ff, pend_in;
   logic [NW-1:0] emitted_ff, emitted_in;
   logic [31:0] seq_ff, seq_in;
   logic [31:0] cursor_ff, cursor_in;
   logic [31:0] appended_ff, appended_in;
   logic [31:0] dropped_ff, dropped_in;
   logic [31:0] downlinked_ff, downlinked_in;
   logic [31:0] assigned_ff, assigned_in;

   logic        rsp_valid_ff;
   logic [31:0] rsp_seq_ff, rsp_time_ff, rsp_pay_ff;
   logic        rsp_rv_ff, rsp_last_ff;
   logic [31:0] rsp_app_ff, rsp_drop_ff, rsp_down_ff, rsp_cur_ff, rsp_next_ff;
   logic [6:0]  rsp_held_ff, rsp_pend_ff;

   logic        accept;
   logic        do_append;
   logic        out_free;
   logic        held_k;
   logic [31:0] tail_seq;
   logic [31:0] cmp_cursor;
   logic [6:0]  limit_c;
   logic [NW-1:0] num_emit;
   logic        emit_row;
   logic        load_row;
   logic        load_resp;
   logic        step_end;

   genvar g;
   generate
      for (g = 0; g < RING_DEPTH; g++) begin : g_cell
         if (g == 0) begin : g_head
            trc_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
               .clock       (clock),
               .move        (move),
               .seq_in      (head_seq),
               .time_in     (head_time),
               .payload_in  (head_payload),
               .seq_out     (cell_seq[g]),
               .time_out    (cell_time[g]),
               .payload_out (cell_payload[g])
            );
         end else begin : g_body
            trc_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
               .clock       (clock),
               .move        (move),
               .seq_in      (cell_seq[g-1]),
               .time_in     (cell_time[g-1]),
               .payload_in  (cell_payload[g-1]),
               .seq_out     (cell_seq[g]),
               .time_out    (cell_time[g]),
               .payload_out (cell_payload[g])
            );
         end
      end
   endgenerate

   assign accept    = req_valid && (state_ff == trc_pkg::ST_IDLE);
   assign do_append = accept && (req_type == trc_pkg::REQ_APPEND);
   assign req_stall = (state_ff != trc_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign tail_seq  = cell_seq[RING_DEPTH-1];
   assign step_end  = (step_ff == STEP_END);

   // the tail cell holds a live row once the turn has passed the empty cells
   assign held_k = (CW'(step_ff) >= (DEPTH_C - held_ff));

   assign cmp_cursor = ((type_ff == trc_pkg::REQ_ACK) && (ack_ff > cursor_ff)) ?
                       ack_ff : cursor_ff;
   assign limit_c  = (limit_ff > MAX_C) ? MAX_C : limit_ff;
   assign num_emit = (NW'(pend_ff) < NW'(limit_c)) ? NW'(pend_ff) : NW'(limit_c);
   assign emit_row = held_k && (tail_seq > cursor_ff) && (emitted_ff < num_emit);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         trc_pkg::ST_IDLE: begin
            if (accept) state_in = trc_pkg::ST_COUNT;
         end
         trc_pkg::ST_COUNT: begin
            if (step_end) begin
               if ((type_ff == trc_pkg::REQ_PEEK) && (pend_in != '0) && (limit_ff != '0))
                  state_in = trc_pkg::ST_EMIT;
               else
                  state_in = trc_pkg::ST_RESP;
            end
         end
         trc_pkg::ST_EMIT: begin
            if (out_free && step_end) state_in = trc_pkg::ST_IDLE;
         end
         trc_pkg::ST_RESP: begin
            if (out_free) state_in = trc_pkg::ST_IDLE;
         end
         default: state_in = trc_pkg::ST_IDLE;
      endcase
   end

   // control and datapath
   always_comb begin
      move          = 1'b0;
      head_seq      = tail_seq;
      head_time     = cell_time[RING_DEPTH-1];
      head_payload  = cell_payload[RING_DEPTH-1];
      step_in       = step_ff;
      held_in       = held_ff;
      pend_in       = pend_ff;
      emitted_in    = emitted_ff;
      seq_in        = seq_ff;
      cursor_in     = cursor_ff;
      appended_in   = appended_ff;
      dropped_in    = dropped_ff;
      downlinked_in = downlinked_ff;
      assigned_in   = assigned_ff;
      load_row      = 1'b0;
      load_resp     = 1'b0;
      unique case (state_ff)
         trc_pkg::ST_IDLE: begin
            step_in    = '0;
            pend_in    = '0;
            emitted_in = '0;
            if (do_append) begin
               move         = 1'b1;
               head_seq     = seq_ff;
               head_time    = req_tick_ms;
               head_payload = PAYLOAD_BITS'(req_sample_payload);
               assigned_in  = seq_ff;
               seq_in       = seq_ff + 32'd1;
               appended_in  = appended_ff + 32'd1;
               if (held_ff == DEPTH_C) begin
                  // oldest row falls off the tail
                  if (tail_seq > cursor_ff) begin
                     dropped_in = dropped_ff + 32'd1;
                     cursor_in  = tail_seq;
                  end
               end else begin
                  held_in = held_ff + CW'(1);
               end
            end
         end
         trc_pkg::ST_COUNT: begin
            move    = 1'b1;
            step_in = step_end ? '0 : step_ff + SW'(1);
            if (held_k && (tail_seq > cmp_cursor)) pend_in = pend_ff + CW'(1);
            if ((type_ff == trc_pkg::REQ_ACK) && held_k &&
                (tail_seq > cursor_ff) && (tail_seq <= ack_ff))
               downlinked_in = downlinked_ff + 32'd1;
            if (step_end) cursor_in = cmp_cursor;
         end
         trc_pkg::ST_EMIT: begin
            if (out_free) begin
               move    = 1'b1;
               step_in = step_end ? '0 : step_ff + SW'(1);
               if (emit_row) begin
                  load_row   = 1'b1;
                  emitted_in = emitted_ff + NW'(1);
               end
            end
         end
         trc_pkg::ST_RESP: begin
            if (out_free) load_resp = 1'b1;
         end
         default: begin
            move = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= trc_pkg::ST_IDLE;
         step_ff       <= '0;
         held_ff       <= '0;
         pend_ff       <= '0;
         emitted_ff    <= '0;
         seq_ff        <= 32'd1;
         cursor_ff     <= '0;
         appended_ff   <= '0;
         dropped_ff    <= '0;
         downlinked_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         held_ff       <= held_in;
         pend_ff       <= pend_in;
         emitted_ff    <= emitted_in;
         seq_ff        <= seq_in;
         cursor_ff     <= cursor_in;
         appended_ff   <= appended_in;
         dropped_ff    <= dropped_in;
         downlinked_ff <= downlinked_in;
         if (load_row || load_resp)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      assigned_ff <= assigned_in;
      if (accept) begin
         type_ff  <= req_type;
         ack_ff   <= req_ack_through;
         limit_ff <= req_peek_limit;
      end
      if (load_row || load_resp) begin
         rsp_app_ff  <= appended_ff;
         rsp_drop_ff <= dropped_ff;
         rsp_down_ff <= downlinked_ff;
         rsp_held_ff <= 7'(held_ff);
         rsp_pend_ff <= 7'(pend_ff);
         rsp_cur_ff  <= cursor_ff;
         rsp_next_ff <= seq_ff;
      end
      if (load_row) begin
         rsp_seq_ff  <= tail_seq;
         rsp_time_ff <= cell_time[RING_DEPTH-1];
         rsp_pay_ff  <= 32'(cell_payload[RING_DEPTH-1]);
         rsp_rv_ff   <= 1'b1;
         rsp_last_ff <= (emitted_ff + NW'(1) == num_emit);
      end else if (load_resp) begin
         rsp_seq_ff  <= (type_ff == trc_pkg::REQ_APPEND) ? assigned_ff : 32'd0;
         rsp_time_ff <= '0;
         rsp_pay_ff  <= '0;
         rsp_rv_ff   <= (type_ff == trc_pkg::REQ_APPEND);
         rsp_last_ff <= 1'b1;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_record_seq        = rsp_seq_ff;
   assign rsp_record_time_ms    = rsp_time_ff;
   assign rsp_record_payload    = rsp_pay_ff;
   assign rsp_record_valid      = rsp_rv_ff;
   assign rsp_last_of_run       = rsp_last_ff;
   assign rsp_appended_total    = rsp_app_ff;
   assign rsp_dropped_total     = rsp_drop_ff;
   assign rsp_downlinked_total  = rsp_down_ff;
   assign rsp_held_rows         = rsp_held_ff;
   assign rsp_pending_rows      = rsp_pend_ff;
   assign rsp_acked_through_seq = rsp_cur_ff;
   assign rsp_next_sequence     = rsp_next_ff;

endmodule

FILE: sv/trc_cell.sv
// ----------------------------------------------------------------------------
// trc_cell
// One row of the ring: takes the row of its neighbour when the chain moves.
// ----------------------------------------------------------------------------
module trc_cell #(
   parameter int PAYLOAD_BITS = trc_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    move,
   input  logic [31:0]             seq_in,
   input  logic [31:0]             time_in,
   input  logic [PAYLOAD_BITS-1:0] payload_in,
   output logic [31:0]             seq_out,
   output logic [31:0]             time_out,
   output logic [PAYLOAD_BITS-1:0] payload_out
);

   logic [31:0]             seq_ff;
   logic [31:0]             time_ff;
   logic [PAYLOAD_BITS-1:0] payload_ff;

   always_ff @(posedge clock) begin
      if (move) begin
         seq_ff     <= seq_in;
         time_ff    <= time_in;
         payload_ff <= payload_in;
      end
   end

   assign seq_out     = seq_ff;
   assign time_out    = time_ff;
   assign payload_out = payload_ff;

endmodule

FILE: dv/telemetry_ring_with_ack_cursor_unit_test.sv
// ----------------------------------------------------------------------------
// telemetry_ring_with_ack_cursor_unit_test
// Drives append, acknowledge, peek and stats items into the ring and checks
// every result item, field by field, against a behavioural copy of the ring.
// ----------------------------------------------------------------------------
module telemetry_ring_with_ack_cursor_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = trc_pkg::RING_DEPTH_DEF;

   typedef struct packed {
      logic [31:0] record_seq;
      logic [31:0] record_time_ms;
      logic [31:0] record_payload;
      logic        record_valid;
      logic        last_of_run;
      logic [31:0] appended_total;
      logic [31:0] dropped_total;
      logic [31:0] downlinked_total;
      logic [6:0]  held_rows;
      logic [6:0]  pending_rows;
      logic [31:0] acked_through_seq;
      logic [31:0] next_sequence;
   } rsp_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = trc_pkg::REQ_STATS;
   logic [31:0] req_sample_payload = '0;
   logic [31:0] req_tick_ms = '0;
   logic [31:0] req_ack_through = '0;
   logic [6:0]  req_peek_limit = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_record_seq;
   logic [31:0] rsp_record_time_ms;
   logic [31:0] rsp_record_payload;
   logic        rsp_record_valid;
   logic        rsp_last_of_run;
   logic [31:0] rsp_appended_total;
   logic [31:0] rsp_dropped_total;
   logic [31:0] rsp_downlinked_total;
   logic [6:0]  rsp_held_rows;
   logic [6:0]  rsp_pending_rows;
   logic [31:0] rsp_acked_through_seq;
   logic [31:0] rsp_next_sequence;
   rsp_item_type got;

   telemetry_ring_with_ack_cursor_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_sample_payload(req_sample_payload), .req_tick_ms(req_tick_ms),
      .req_ack_through(req_ack_through), .req_peek_limit(req_peek_limit),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_record_seq(rsp_record_seq), .rsp_record_time_ms(rsp_record_time_ms),
      .rsp_record_payload(rsp_record_payload), .rsp_record_valid(rsp_record_valid),
      .rsp_last_of_run(rsp_last_of_run), .rsp_appended_total(rsp_appended_total),
      .rsp_dropped_total(rsp_dropped_total),
      .rsp_downlinked_total(rsp_downlinked_total), .rsp_held_rows(rsp_held_rows),
      .rsp_pending_rows(rsp_pending_rows),
      .rsp_acked_through_seq(rsp_acked_through_seq),
      .rsp_next_sequence(rsp_next_sequence)
   );

   assign got = {rsp_record_seq, rsp_record_time_ms, rsp_record_payload,
                 rsp_record_valid, rsp_last_of_run, rsp_appended_total,
                 rsp_dropped_total, rsp_downlinked_total, rsp_held_rows,
                 rsp_pending_rows, rsp_acked_through_seq, rsp_next_sequence};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow ring
   logic [31:0] sh_seq [DEPTH];
   logic [31:0] sh_time [DEPTH];
   logic [31:0] sh_pay [DEPTH];
   int unsigned sh_wr, sh_held;
   logic [31:0] sh_next, sh_cursor, sh_app, sh_drop, sh_down;

   rsp_item_type expected_rsp [$];
   int          errors = 0;
   int          items_sent = 0;
   int          rows_peeked = 0;
   bit          sender_idle_on = 1'b1;
   bit          receiver_idle_on = 1'b1;

   function automatic int unsigned oldest();
      return (sh_wr + DEPTH - sh_held) % DEPTH;
   endfunction

   function automatic logic [6:0] pending_now();
      int unsigned idx, n;
      idx = oldest();
      n = 0;
      for (int i = 0; i < sh_held; i++) begin
         if (sh_seq[idx] > sh_cursor) n++;
         idx = (idx + 1) % DEPTH;
      end
      return n[6:0];
   endfunction

   function automatic rsp_item_type stats_item(logic [6:0] pend);
      rsp_item_type r;
      r = '0;
      r.last_of_run = 1'b1;
      r.appended_total = sh_app;
      r.dropped_total = sh_drop;
      r.downlinked_total = sh_down;
      r.held_rows = sh_held[6:0];
      r.pending_rows = pend;
      r.acked_through_seq = sh_cursor;
      r.next_sequence = sh_next;
      return r;
   endfunction

   task automatic predict_ring(logic [1:0] kind, logic [31:0] pay, logic [31:0] tick,
                               logic [31:0] ack, logic [6:0] limit);
      rsp_item_type r;
      logic [31:0] victim, assigned;
      logic [6:0] pend;
      int unsigned idx, lim, n;
      unique case (kind)
         trc_pkg::REQ_APPEND: begin
            if (sh_held >= DEPTH) begin
               victim = sh_seq[sh_wr];
               if (victim > sh_cursor) begin
                  sh_drop++;
                  sh_cursor = victim;
               end
               sh_held = DEPTH - 1;
            end
            assigned = sh_next;
            sh_seq[sh_wr] = assigned;
            sh_time[sh_wr] = tick;
            sh_pay[sh_wr] = pay;
            sh_next++;
            sh_wr = (sh_wr + 1) % DEPTH;
            sh_held++;
            sh_app++;
            r = stats_item(pending_now());
            r.record_seq = assigned;
            r.record_valid = 1'b1;
            expected_rsp.push_back(r);
         end
         trc_pkg::REQ_ACK: begin
            if (ack > sh_cursor) begin
               idx = oldest();
               for (int i = 0; i < sh_held; i++) begin
                  if (sh_seq[idx] > sh_cursor && sh_seq[idx] <= ack) sh_down++;
                  idx = (idx + 1) % DEPTH;
               end
               sh_cursor = ack;
            end
            expected_rsp.push_back(stats_item(pending_now()));
         end
         trc_pkg::REQ_PEEK: begin
            pend = pending_now();
            lim = (limit > trc_pkg::MAX_RESULTS) ? trc_pkg::MAX_RESULTS : limit;
            idx = oldest();
            n = 0;
            for (int i = 0; i < sh_held && n < lim; i++) begin
               if (sh_seq[idx] > sh_cursor) begin
                  r = stats_item(pend);
                  r.last_of_run = 1'b0;
                  r.record_seq = sh_seq[idx];
                  r.record_time_ms = sh_time[idx];
                  r.record_payload = sh_pay[idx];
                  r.record_valid = 1'b1;
                  expected_rsp.push_back(r);
                  n++;
               end
               idx = (idx + 1) % DEPTH;
            end
            if (n == 0) expected_rsp.push_back(stats_item(pend));
            else expected_rsp[$].last_of_run = 1'b1;
            rows_peeked += n;
         end
         default: expected_rsp.push_back(stats_item(pending_now()));
      endcase
   endtask

   task automatic send_request(logic [1:0] kind, logic [31:0] pay = '0,
                               logic [31:0] tick = '0, logic [31:0] ack = '0,
                               logic [6:0] limit = '0);
      int gap;
      if (sender_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_type <= kind;
      req_sample_payload <= pay;
      req_tick_ms <= tick;
      req_ack_through <= ack;
      req_peek_limit <= limit;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_ring(kind, pay, tick, ack, limit);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic report_mismatch(string what, logic [31:0] g, logic [31:0] e);
      errors++;
      $display("mismatch %s: got %0h expected %0h", what, g, e);
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected result item", got.record_seq, 32'd0);
         end else begin
            e = expected_rsp.pop_front();
            if (got.record_seq !== e.record_seq)
               report_mismatch("record_seq", got.record_seq, e.record_seq);
            if (got.record_time_ms !== e.record_time_ms)
               report_mismatch("record_time_ms", got.record_time_ms, e.record_time_ms);
            if (got.record_payload !== e.record_payload)
               report_mismatch("record_payload", got.record_payload, e.record_payload);
            if (got.record_valid !== e.record_valid)
               report_mismatch("record_valid", 32'(got.record_valid),
                               32'(e.record_valid));
            if (got.last_of_run !== e.last_of_run)
               report_mismatch("last_of_run", 32'(got.last_of_run), 32'(e.last_of_run));
            if (got.appended_total !== e.appended_total)
               report_mismatch("appended_total", got.appended_total, e.appended_total);
            if (got.dropped_total !== e.dropped_total)
               report_mismatch("dropped_total", got.dropped_total, e.dropped_total);
            if (got.downlinked_total !== e.downlinked_total)
               report_mismatch("downlinked_total", got.downlinked_total,
                               e.downlinked_total);
            if (got.held_rows !== e.held_rows)
               report_mismatch("held_rows", 32'(got.held_rows), 32'(e.held_rows));
            if (got.pending_rows !== e.pending_rows)
               report_mismatch("pending_rows", 32'(got.pending_rows),
                               32'(e.pending_rows));
            if (got.acked_through_seq !== e.acked_through_seq)
               report_mismatch("acked_through_seq", got.acked_through_seq,
                               e.acked_through_seq);
            if (got.next_sequence !== e.next_sequence)
               report_mismatch("next_sequence", got.next_sequence, e.next_sequence);
         end
      end
   end

   // receiver stall bursts
   initial begin
      int len;
      forever begin
         @(negedge clock);
         if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
            len = $urandom_range(1, 18);
            rsp_stall <= 1'b1;
            repeat (len) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic test_empty_ring();
      send_request(trc_pkg::REQ_STATS);
      send_request(trc_pkg::REQ_PEEK, '0, '0, '0, 7'd64);
      send_request(trc_pkg::REQ_ACK, '0, '0, 32'd0);
   endtask

   task automatic test_append_and_peek();
      send_request(trc_pkg::REQ_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(trc_pkg::REQ_APPEND, 32'h0, 32'h0);
      send_request(trc_pkg::REQ_APPEND, 32'hA5A5_5A5A, 32'h1234_5678);
      send_request(trc_pkg::REQ_PEEK, '0, '0, '0, 7'd0);
      send_request(trc_pkg::REQ_PEEK, '0, '0, '0, 7'd2);
      send_request(trc_pkg::REQ_PEEK, '0, '0, '0, 7'd127);
   endtask

   task automatic test_acknowledge();
      send_request(trc_pkg::REQ_ACK, '0, '0, 32'd2);
      send_request(trc_pkg::REQ_ACK, '0, '0, 32'd1);  // stale
      send_request(trc_pkg::REQ_PEEK, '0, '0, '0, 7'd64);
      send_request(trc_pkg::REQ_ACK, '0, '0, 32'd3);
      send_request(trc_pkg::REQ_PEEK, '0, '0, '0, 7'd5);
   endtask

   task automatic test_overwrite();
      // fill past depth so pending rows are overwritten and counted as drops
      for (int i = 0; i < DEPTH + 4; i++)
         send_request(trc_pkg::REQ_APPEND, $urandom, $urandom);
      send_request(trc_pkg::REQ_PEEK, '0, '0, '0, 7'd64);
      send_request(trc_pkg::REQ_ACK, '0, '0, 32'hFFFF_FFFF);
      send_request(trc_pkg::REQ_APPEND, 32'h8000_0001, 32'h7FFF_FFFE);
      send_request(trc_pkg::REQ_PEEK, '0, '0, '0, 7'd64);
   endtask

   task automatic test_random_mix();
      int pick;
      for (int i = 0; i < 45; i++) begin
         if (i == 30) begin
            sender_idle_on = 1'b0;
            receiver_idle_on = 1'b0;
         end
         pick = $urandom_range(0, 9);
         if (pick < 5)
            send_request(trc_pkg::REQ_APPEND, $urandom, $urandom);
         else if (pick < 7)
            send_request(trc_pkg::REQ_ACK, '0, '0,
                         ($urandom_range(0, 7) == 0) ? $urandom
                         : sh_cursor + $urandom_range(0, 6) - 2, 7'($urandom));
         else if (pick < 9)
            send_request(trc_pkg::REQ_PEEK, $urandom, $urandom, $urandom,
                         ($urandom_range(0, 5) == 0) ? 7'($urandom)
                         : 7'($urandom_range(0, 8)));
         else
            send_request(trc_pkg::REQ_STATS, $urandom, $urandom, $urandom,
                         7'($urandom));
      end
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         sh_seq[i] = '0; sh_time[i] = '0; sh_pay[i] = '0;
      end
      sh_wr = 0; sh_held = 0; sh_next = 32'd1; sh_cursor = '0;
      sh_app = '0; sh_drop = '0; sh_down = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_empty_ring();
      test_append_and_peek();
      test_acknowledge();
      test_overwrite();
      test_random_mix();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (2 * DEPTH + 10) @(negedge clock);
      $display("%0d request items sent, %0d rows returned by peeks, drops %0d",
               items_sent, rows_peeked, sh_drop);
      if (errors == 0 && expected_rsp.size() == 0)
         $display("telemetry_ring_with_ack_cursor_unit_test passed");
      else
         $display("telemetry_ring_with_ack_cursor_unit_test failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("telemetry_ring_with_ack_cursor_unit_test failed");
      $finish;
   end

endmodule
